@@ src/axis_angle_rotation_matrix_assert.svh @@
// assertion macros shared by the rotation matrix rtl
// each expects clk and rst_n in scope
`ifndef AXIS_ANGLE_ROTATION_MATRIX_ASSERT_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define AAR_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aar: assertion failed");
// next-cycle implication
`define AAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aar: assertion failed");
`else
`define AAR_ASSERT(label, ante, cons)
`define AAR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ src/aar_pkg.sv @@
`default_nettype none

package aar_pkg;

    // field widths
    localparam int AXIS_W      = 16;
    localparam int OUT_W       = 16;
    localparam int ANGLE_SHIFT = 18;   // Q3.12 angle to Q30

    // internal widths
    localparam int THETA_W = 35;       // negated angle in Q30, before reduction
    localparam int CW      = 34;       // cordic x, y, z and s, c, t
    localparam int AB_W    = 2 * AXIS_W;
    localparam int SPLIT   = 17;       // t is cut into a signed high and unsigned low part
    localparam int HI_W    = CW - SPLIT + AB_W;
    localparam int LO_W    = SPLIT + 1 + AB_W;
    localparam int SA_W    = CW + AXIS_W;
    localparam int PROD_W  = CW + AB_W;
    localparam int SUM_W   = 68;
    localparam int RND_W   = SUM_W - 30;
    localparam int N_AB    = 6;
    localparam int N_ENT   = 9;

    // angle and scale constants in Q30
    localparam logic signed [THETA_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [THETA_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [CW-1:0]      GAIN_Q30    = 34'sd652032874;
    localparam logic signed [CW-1:0]      ONE_Q30     = 34'sd1073741824;
    localparam logic signed [SUM_W-1:0]   RND_HALF    = 68'sd536870912;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7fff;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

    localparam logic signed [CW-1:0] ATAN_HEAD [10] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149
    };

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic signed [OUT_W-1:0]  entry_t;

    typedef struct packed {
        axis_t x;
        axis_t y;
        axis_t z;
    } axis_vec_t;

    typedef struct packed {
        axis_t                   axis_x;
        axis_t                   axis_y;
        axis_t                   axis_z;
        logic signed [AXIS_W-1:0] turn_angle;
    } in_beat_t;

    typedef struct packed {
        entry_t e11;
        entry_t e12;
        entry_t e13;
        entry_t e21;
        entry_t e22;
        entry_t e23;
        entry_t e31;
        entry_t e32;
        entry_t e33;
    } out_beat_t;

    // arctangent of 2^-idx in Q30
    function automatic logic signed [CW-1:0] atan_q30(input int unsigned idx);
        logic signed [CW-1:0] r;
        if (idx < 10)
        begin
            r = ATAN_HEAD[idx[3:0]];
        end
        else if (idx > 30)
        begin
            r = '0;
        end
        else
        begin
            r = ONE_Q30 >>> idx;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/aar_in_if.sv @@
`default_nettype none

interface aar_in_if import aar_pkg::*; ();
    logic     valid;
    logic     ready;
    in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/aar_out_if.sv @@
`default_nettype none

interface aar_out_if import aar_pkg::*; ();
    logic      valid;
    logic      ready;
    out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/aar_cordic.sv @@
`default_nettype none
`include "axis_angle_rotation_matrix_assert.svh"

module aar_cordic import aar_pkg::*; #(
    parameter int STEPS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire logic signed [THETA_W-1:0] theta,
    input  wire axis_vec_t            axis_in,
    output logic                      out_valid,
    output logic                      flip_out,
    output logic signed [CW-1:0]      x_out,
    output logic signed [CW-1:0]      y_out,
    output axis_vec_t                 axis_out
);

    function automatic logic out_of_range(input logic signed [THETA_W-1:0] z);
        return (z > HALF_PI_Q30) || (z < -HALF_PI_Q30);
    endfunction

    function automatic logic signed [THETA_W-1:0] reduce_z(
        input logic signed [THETA_W-1:0] z);
        logic signed [THETA_W-1:0] r;
        if (z > HALF_PI_Q30)
        begin
            r = z - PI_Q30;
        end
        else if (z < -HALF_PI_Q30)
        begin
            r = z + PI_Q30;
        end
        else
        begin
            r = z;
        end
        return r;
    endfunction

    // quadrant reduction, two half-pi folds per stage
    logic                      vld_r1_reg, vld_r2_reg;
    logic                      flip_r1_reg, flip_r2_reg;
    logic                      flip_r1_next, flip_r2_next;
    logic signed [THETA_W-1:0] z_r1_reg, z_r2_reg;
    logic signed [THETA_W-1:0] z_r1_next, z_r2_next;
    logic signed [THETA_W-1:0] z_r1_mid, z_r2_mid;
    axis_vec_t                 axis_r1_reg, axis_r2_reg;

    always_comb
    begin
        z_r1_mid     = reduce_z(theta);
        z_r1_next    = reduce_z(z_r1_mid);
        flip_r1_next = out_of_range(theta) ^ out_of_range(z_r1_mid);
        z_r2_mid     = reduce_z(z_r1_reg);
        z_r2_next    = reduce_z(z_r2_mid);
        flip_r2_next = flip_r1_reg ^ out_of_range(z_r1_reg) ^ out_of_range(z_r2_mid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_r1_reg <= 1'b0;
            vld_r2_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_r1_reg <= in_valid;
            vld_r2_reg <= vld_r1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z_r1_reg    <= z_r1_next;
            flip_r1_reg <= flip_r1_next;
            axis_r1_reg <= axis_in;
            z_r2_reg    <= z_r2_next;
            flip_r2_reg <= flip_r2_next;
            axis_r2_reg <= axis_r1_reg;
        end
    end

    // rotation stages, one micro-rotation per register
    logic signed [CW-1:0] x_in   [STEPS];
    logic signed [CW-1:0] y_in   [STEPS];
    logic signed [CW-1:0] z_in   [STEPS];
    logic signed [CW-1:0] x_next [STEPS];
    logic signed [CW-1:0] y_next [STEPS];
    logic signed [CW-1:0] z_next [STEPS];
    logic signed [CW-1:0] x_reg  [STEPS];
    logic signed [CW-1:0] y_reg  [STEPS];
    logic signed [CW-1:0] z_reg  [STEPS];
    axis_vec_t            axis_st_in [STEPS];
    axis_vec_t            axis_reg   [STEPS];
    logic [STEPS-1:0]     flip_in;
    logic [STEPS-1:0]     flip_reg;
    logic [STEPS-1:0]     vld_in;
    logic [STEPS-1:0]     vld_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_iter
        localparam logic signed [CW-1:0] ANG = atan_q30(i);

        if (i == 0)
        begin : g_first
            assign x_in[i]       = GAIN_Q30;
            assign y_in[i]       = '0;
            assign z_in[i]       = z_r2_reg[CW-1:0];
            assign axis_st_in[i] = axis_r2_reg;
            assign flip_in[i]    = flip_r2_reg;
            assign vld_in[i]     = vld_r2_reg;
        end
        else
        begin : g_rest
            assign x_in[i]       = x_reg[i-1];
            assign y_in[i]       = y_reg[i-1];
            assign z_in[i]       = z_reg[i-1];
            assign axis_st_in[i] = axis_reg[i-1];
            assign flip_in[i]    = flip_reg[i-1];
            assign vld_in[i]     = vld_reg[i-1];
        end

        // turn toward zero residual angle
        always_comb
        begin
            if (z_in[i] >= 0)
            begin
                x_next[i] = x_in[i] - (y_in[i] >>> i);
                y_next[i] = y_in[i] + (x_in[i] >>> i);
                z_next[i] = z_in[i] - ANG;
            end
            else
            begin
                x_next[i] = x_in[i] + (y_in[i] >>> i);
                y_next[i] = y_in[i] - (x_in[i] >>> i);
                z_next[i] = z_in[i] + ANG;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i] <= vld_in[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[i]    <= x_next[i];
                y_reg[i]    <= y_next[i];
                z_reg[i]    <= z_next[i];
                axis_reg[i] <= axis_st_in[i];
                flip_reg[i] <= flip_in[i];
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign flip_out  = flip_reg[STEPS-1];
    assign x_out     = x_reg[STEPS-1];
    assign y_out     = y_reg[STEPS-1];
    assign axis_out  = axis_reg[STEPS-1];

    // checks
    `AAR_ASSERT(a_reduced_range, vld_r2_reg, (z_r2_reg <= HALF_PI_Q30) && (z_r2_reg >= -HALF_PI_Q30))
    `AAR_ASSERT_NEXT(a_beat_enters, adv && in_valid, vld_r1_reg)
    `AAR_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld_reg) && $stable(vld_r1_reg) && $stable(vld_r2_reg))

endmodule

`default_nettype wire

@@ src/axis_angle_rotation_matrix.sv @@
// Axis-angle rotation matrix, fixed point.
// item channel (aar_in_if, sink): unit axis x, y, z in Q1.14 and the turn angle
// in Q3.12 radians. result channel (aar_out_if, source): the nine entries
// e11..e33 of the 3x3 rotation matrix in Q1.14, saturated. A beat moves on a
// clock edge with valid and ready both high; each item beat gives one result beat.
// sin and cos of the negated angle come from a pipelined rotation-mode CORDIC
// (two quadrant folding stages, then one register per CORDIC step), followed by
// six stages of products, sums and round/saturate, the last being the output
// register.
// CORDIC_STEPS + 8 register stages lie between acceptance and the result beat.
// Throughput: one beat per cycle while the receiver keeps taking results.
// The whole pipeline shifts as one while the output register is empty or taken;
// when the receiver stalls with a result waiting, every stage holds and
// item.ready drops in the same cycle, so nothing is lost or repeated.
// Reset (rst_n, asynchronous, active low) clears all valid bits; no state is
// kept between items.
`default_nettype none
`include "axis_angle_rotation_matrix_assert.svh"

module axis_angle_rotation_matrix import aar_pkg::*; #(
    parameter int FRAC_BITS    = 14,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    aar_in_if.sink    item,
    aar_out_if.source result
);

    // product pairs: xx, yy, zz, xy, xz, yz
    localparam int AB_A [N_AB] = '{0, 1, 2, 0, 0, 1};
    localparam int AB_B [N_AB] = '{0, 1, 2, 1, 2, 2};

    localparam logic signed [CW-1:0] T_LO = -34'sd256;
    localparam logic signed [CW-1:0] T_HI = 34'sd2147483904;

    // round to nearest by 30 bits, then clamp to the entry range
    function automatic entry_t sat_round(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] biased;
        logic signed [RND_W-1:0] r;
        entry_t                  q;
        biased = v + RND_HALF;
        r      = biased[SUM_W-1:30];
        if (r > RND_W'(OUT_MAX))
        begin
            q = OUT_MAX;
        end
        else if (r < RND_W'(OUT_MIN))
        begin
            q = OUT_MIN;
        end
        else
        begin
            q = r[OUT_W-1:0];
        end
        return q;
    endfunction

    logic                      adv;
    logic signed [THETA_W-1:0] theta;
    axis_vec_t                 axis_in;
    logic                      cor_valid, cor_flip;
    logic signed [CW-1:0]      cor_x, cor_y;
    axis_vec_t                 cor_axis;

    logic [4:0] vld_reg;
    logic       res_vld_reg;
    out_beat_t  res_reg;
    out_beat_t  res_next;

    // whole pipeline moves while the output slot is free or being taken
    assign adv        = !res_vld_reg || result.ready;
    assign item.ready = adv;

    // negated angle in Q30
    assign theta = -({{(THETA_W-AXIS_W){item.data.turn_angle[AXIS_W-1]}},
                      item.data.turn_angle} <<< ANGLE_SHIFT);
    assign axis_in.x = item.data.axis_x;
    assign axis_in.y = item.data.axis_y;
    assign axis_in.z = item.data.axis_z;

    aar_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (item.valid),
        .theta     (theta),
        .axis_in   (axis_in),
        .out_valid (cor_valid),
        .flip_out  (cor_flip),
        .x_out     (cor_x),
        .y_out     (cor_y),
        .axis_out  (cor_axis)
    );

    // stage 0: quadrant sign, axis products
    logic signed [CW-1:0]   s_p0_next, c_p0_next, s_p0_reg, c_p0_reg;
    logic signed [AB_W-1:0] ab_p0_next [N_AB];
    logic signed [AB_W-1:0] ab_p0_reg  [N_AB];
    axis_t                  ax_p0 [3];
    axis_vec_t              axis_p0_reg;

    always_comb
    begin
        s_p0_next = cor_flip ? -cor_y : cor_y;
        c_p0_next = cor_flip ? -cor_x : cor_x;
        ax_p0[0]  = cor_axis.x;
        ax_p0[1]  = cor_axis.y;
        ax_p0[2]  = cor_axis.z;
        for (int k = 0; k < N_AB; k++)
        begin
            ab_p0_next[k] = AB_W'(ax_p0[AB_A[k]]) * AB_W'(ax_p0[AB_B[k]]);
        end
    end

    // stage 1: t = 1 - c
    logic signed [CW-1:0]   t_p1_next, t_p1_reg, s_p1_reg, c_p1_reg;
    logic signed [AB_W-1:0] ab_p1_reg [N_AB];
    axis_vec_t              axis_p1_reg;

    assign t_p1_next = ONE_Q30 - c_p0_reg;

    // stage 2: split products t*ab, s*a, c scaled
    logic signed [CW-SPLIT-1:0] t_hi;
    logic signed [SPLIT:0]      t_lo;
    logic signed [HI_W-1:0]     phi_next [N_AB];
    logic signed [HI_W-1:0]     phi_reg  [N_AB];
    logic signed [LO_W-1:0]     plo_next [N_AB];
    logic signed [LO_W-1:0]     plo_reg  [N_AB];
    logic signed [SA_W-1:0]     sa_next  [3];
    logic signed [SA_W-1:0]     sa_p2_reg [3];
    logic signed [SUM_W-1:0]    cd_next, cd_p2_reg;
    axis_t                      ax_p1 [3];

    always_comb
    begin
        t_hi     = t_p1_reg[CW-1:SPLIT];
        t_lo     = {1'b0, t_p1_reg[SPLIT-1:0]};
        ax_p1[0] = axis_p1_reg.x;
        ax_p1[1] = axis_p1_reg.y;
        ax_p1[2] = axis_p1_reg.z;
        for (int k = 0; k < N_AB; k++)
        begin
            phi_next[k] = HI_W'(t_hi) * HI_W'(ab_p1_reg[k]);
            plo_next[k] = LO_W'(t_lo) * LO_W'(ab_p1_reg[k]);
        end
        for (int j = 0; j < 3; j++)
        begin
            sa_next[j] = SA_W'(s_p1_reg) * SA_W'(ax_p1[j]);
        end
        cd_next = SUM_W'(c_p1_reg) <<< FRAC_BITS;
    end

    // stage 3: join the partial products
    logic signed [PROD_W-1:0] full_next [N_AB];
    logic signed [PROD_W-1:0] full_reg  [N_AB];
    logic signed [SA_W-1:0]   sa_p3_reg [3];
    logic signed [SUM_W-1:0]  cd_p3_reg;

    always_comb
    begin
        for (int k = 0; k < N_AB; k++)
        begin
            full_next[k] = (PROD_W'(phi_reg[k]) <<< SPLIT) + PROD_W'(plo_reg[k]);
        end
    end

    // stage 4: floor by FRAC_BITS and form the nine sums
    logic signed [PROD_W-1:0] tab_sh [N_AB];
    logic signed [SUM_W-1:0]  tab    [N_AB];
    logic signed [SUM_W-1:0]  sa_ext [3];
    logic signed [SUM_W-1:0]  v_next [N_ENT];
    logic signed [SUM_W-1:0]  v_reg  [N_ENT];

    always_comb
    begin
        for (int k = 0; k < N_AB; k++)
        begin
            tab_sh[k] = full_reg[k] >>> FRAC_BITS;
            tab[k]    = SUM_W'(tab_sh[k]);
        end
        for (int j = 0; j < 3; j++)
        begin
            sa_ext[j] = SUM_W'(sa_p3_reg[j]);
        end
        v_next[0] = cd_p3_reg + tab[0];
        v_next[1] = tab[3] - sa_ext[2];
        v_next[2] = tab[4] + sa_ext[1];
        v_next[3] = tab[3] + sa_ext[2];
        v_next[4] = cd_p3_reg + tab[1];
        v_next[5] = tab[5] - sa_ext[0];
        v_next[6] = tab[4] - sa_ext[1];
        v_next[7] = tab[5] + sa_ext[0];
        v_next[8] = cd_p3_reg + tab[2];
    end

    // stage 5: round and saturate into the output register
    always_comb
    begin
        res_next.e11 = sat_round(v_reg[0]);
        res_next.e12 = sat_round(v_reg[1]);
        res_next.e13 = sat_round(v_reg[2]);
        res_next.e21 = sat_round(v_reg[3]);
        res_next.e22 = sat_round(v_reg[4]);
        res_next.e23 = sat_round(v_reg[5]);
        res_next.e31 = sat_round(v_reg[6]);
        res_next.e32 = sat_round(v_reg[7]);
        res_next.e33 = sat_round(v_reg[8]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            res_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[3:0], cor_valid};
            res_vld_reg <= vld_reg[4];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_p0_reg    <= s_p0_next;
            c_p0_reg    <= c_p0_next;
            ab_p0_reg   <= ab_p0_next;
            axis_p0_reg <= cor_axis;

            t_p1_reg    <= t_p1_next;
            s_p1_reg    <= s_p0_reg;
            c_p1_reg    <= c_p0_reg;
            ab_p1_reg   <= ab_p0_reg;
            axis_p1_reg <= axis_p0_reg;

            phi_reg     <= phi_next;
            plo_reg     <= plo_next;
            sa_p2_reg   <= sa_next;
            cd_p2_reg   <= cd_next;

            full_reg    <= full_next;
            sa_p3_reg   <= sa_p2_reg;
            cd_p3_reg   <= cd_p2_reg;

            v_reg       <= v_next;

            res_reg     <= res_next;
        end
    end

    assign result.valid = res_vld_reg;
    assign result.data  = res_reg;

    // checks
    `AAR_ASSERT_NEXT(a_last_stage_to_out, adv && vld_reg[4], res_vld_reg)
    `AAR_ASSERT_NEXT(a_stall_holds_pipe, !adv, $stable(vld_reg) && $stable(res_vld_reg))
    `AAR_ASSERT(a_t_range, vld_reg[1], (t_p1_reg >= T_LO) && (t_p1_reg <= T_HI))

endmodule

`default_nettype wire
